### sv/csa_pkg.sv
// Package for the circular server assigner: result kind codes, field widths
// and the command and status structs between the controller and the datapath.
// No dependencies.
package csa_pkg;

   localparam int DATA_W   = 32;
   localparam int KIND_W   = 2;
   localparam int SERVER_W = 4;
   localparam int CSR_W    = 5;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_ASSIGNED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DROPPED  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BUSIEST  = 2'd2;

   // Requested action.
   localparam logic ACTION_ASSIGN = 1'b0;
   localparam logic ACTION_REPORT = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // latch a new request and issue the first read
      logic step;       // move to the next server entry
      logic to_list;    // restart the scan at server 0 for the listing pass
      logic track_max;  // fold the current count into the running maximum
      logic commit;     // assign the current server and emit the result
      logic drop;       // emit a dropped result
      logic list_emit;  // emit the current server as a busiest entry
   } csa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic free;        // current server is free at the arrival time
      logic search_end;  // current entry is the last one of the search
      logic last_entry;  // current index is the last server in use
      logic match;       // current count equals the largest count
      logic last_match;  // current index is the last one holding that count
      logic slot_free;   // the result register can take a result this cycle
   } csa_status_type;

endpackage

### sv/circular_server_assigner.sv
// Top level of the circular server assigner.
// Depends on csa_pkg, csa_controller, csa_datapath and csa_ram.
//
// The block hands requests to a ring of servers. Each assign request
// starts its search one server past where the previous request started,
// wrapping at the number of servers in use, and takes the first server
// whose finish time is at most the request's arrival time. That server's
// finish time becomes arrival plus service time (saturating) and its served
// count rises by one (saturating); the result reports the server and its new
// count. When every server is busy the request comes back as dropped. A
// report request lists every server whose served count equals the largest
// count, in index order, one result each, with last set on the final one.
// The server tables sit in two RAMs with a registered read and are
// examined one entry per clock while the result channel does not stall. An
// assign request is accepted and then examines servers from its start point
// until one is free or all have been tried. A report makes one pass over all
// servers in use to find the largest count, and a second pass walks from
// server 0 and stops at the last server that holds that count. Stalls on the
// result channel hold the scan. A new request is taken as soon as the
// previous one has placed its last result in the output register, even while
// that result still waits to be taken. The server count register may be
// written at any time the block is idle; it is clamped to 1..MAX_SERVERS.
module circular_server_assigner #(
   parameter int MAX_SERVERS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // Request channel.
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_action,
   input  logic [csa_pkg::DATA_W-1:0]   req_arrival_time,
   input  logic [csa_pkg::DATA_W-1:0]   req_service_time,
   // Result channel.
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [csa_pkg::KIND_W-1:0]   rsp_kind,
   output logic [csa_pkg::SERVER_W-1:0] rsp_server,
   output logic [csa_pkg::DATA_W-1:0]   rsp_served,
   output logic                         rsp_last,
   // Configuration write channel: number of servers in use.
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [csa_pkg::CSR_W-1:0]    csr_num_servers
);

   import csa_pkg::*;

   csa_cmd_type    cmd;
   csa_status_type status;

   // The configuration register takes a write in any cycle.
   assign csr_ready = 1'b1;

   // The controller sequences the search, the maximum pass and the listing pass.
   csa_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath owns all server state and the result register.
   csa_datapath #(.MAX_SERVERS(MAX_SERVERS)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_action       (req_action),
      .req_arrival_time (req_arrival_time),
      .req_service_time (req_service_time),
      .csr_write        (csr_valid),
      .csr_num_servers  (csr_num_servers),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_server       (rsp_server),
      .rsp_served       (rsp_served),
      .rsp_last         (rsp_last)
   );

endmodule

### sv/csa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module csa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/csa_controller.sv
// Controller state machine of the circular server assigner.
// Depends on csa_pkg for the command and status structs.
module csa_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_action,
   output logic                    req_ready,
   input  csa_pkg::csa_status_type status,
   output csa_pkg::csa_cmd_type    cmd
);

   import csa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE      = 4'b0001,
      S_REQ_SCAN  = 4'b0010,
      S_MAX_SCAN  = 4'b0100,
      S_LIST_SCAN = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (req_action == ACTION_REPORT) ? S_MAX_SCAN : S_REQ_SCAN;
            end
         end
         S_REQ_SCAN: begin
            if (status.free) begin
               if (status.slot_free) begin
                  cmd.commit = 1'b1;
                  state_in   = S_IDLE;
               end
            end else if (status.search_end) begin
               if (status.slot_free) begin
                  cmd.drop = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_MAX_SCAN: begin
            cmd.track_max = 1'b1;
            if (status.last_entry) begin
               cmd.to_list = 1'b1;
               state_in    = S_LIST_SCAN;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_LIST_SCAN: begin
            if (status.match) begin
               if (status.slot_free) begin
                  cmd.list_emit = 1'b1;
                  if (status.last_match) begin
                     state_in = S_IDLE;
                  end else begin
                     cmd.step = 1'b1;
                  end
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/csa_datapath.sv
// Datapath of the circular server assigner: server tables, scan index,
// start pointer, running maximum and the result register.
// Depends on csa_pkg and csa_ram.
module csa_datapath #(
   parameter int MAX_SERVERS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_action,
   input  logic [csa_pkg::DATA_W-1:0]        req_arrival_time,
   input  logic [csa_pkg::DATA_W-1:0]        req_service_time,
   input  logic                              csr_write,
   input  logic [csa_pkg::CSR_W-1:0]         csr_num_servers,
   input  csa_pkg::csa_cmd_type              cmd,
   output csa_pkg::csa_status_type           status,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [csa_pkg::KIND_W-1:0]        rsp_kind,
   output logic [csa_pkg::SERVER_W-1:0]      rsp_server,
   output logic [csa_pkg::DATA_W-1:0]        rsp_served,
   output logic                              rsp_last
);

   import csa_pkg::*;

   localparam int IDX_W   = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_W   = $clog2(MAX_SERVERS + 1);
   localparam int N_RESET = (MAX_SERVERS < 16) ? MAX_SERVERS : 16;

   logic [CNT_W-1:0]       n_ff, n_in;
   logic [IDX_W-1:0]       sp_ff, sp_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [DATA_W-1:0]      arrival_ff, arrival_in;
   logic [DATA_W-1:0]      service_ff, service_in;
   logic [DATA_W-1:0]      best_ff, best_in;
   logic [IDX_W-1:0]       last_idx_ff, last_idx_in;
   logic [MAX_SERVERS-1:0] valid_ff, valid_in;
   logic                   rd_valid_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]      rsp_kind_ff, rsp_kind_in;
   logic [SERVER_W-1:0]    rsp_server_ff, rsp_server_in;
   logic [DATA_W-1:0]      rsp_served_ff, rsp_served_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]  n_clamped;
   logic [CNT_W-1:0]  idx_next_wide;
   logic              last_entry;
   logic [IDX_W-1:0]  idx_next;
   logic [IDX_W-1:0]  start_idx;
   logic [IDX_W-1:0]  sp_next;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] fin_q, cnt_q;
   logic [DATA_W-1:0] fin_rd, cnt_rd;
   logic [DATA_W:0]   sum_wide;
   logic [DATA_W-1:0] fin_wr, cnt_wr;
   logic              slot_free;

   // Register value clamped into 1..MAX_SERVERS.
   always_comb begin
      if (csr_num_servers == '0) begin
         n_clamped = CNT_W'(1);
      end else if (int'(csr_num_servers) > MAX_SERVERS) begin
         n_clamped = CNT_W'(MAX_SERVERS);
      end else begin
         n_clamped = CNT_W'(csr_num_servers);
      end
   end

   assign idx_next_wide = CNT_W'(idx_ff) + CNT_W'(1);
   assign last_entry    = (idx_next_wide == n_ff);
   assign idx_next      = last_entry ? '0 : IDX_W'(idx_next_wide);
   assign start_idx     = ((req_action == ACTION_ASSIGN) && (CNT_W'(sp_ff) < n_ff)) ? sp_ff : '0;
   assign sp_next       = ((CNT_W'(sp_ff) + CNT_W'(1)) == n_ff) ? '0 : IDX_W'(CNT_W'(sp_ff) + CNT_W'(1));

   always_comb begin
      priority if (cmd.accept) begin
         rd_addr = start_idx;
      end else if (cmd.step) begin
         rd_addr = idx_next;
      end else if (cmd.to_list) begin
         rd_addr = '0;
      end else begin
         rd_addr = idx_ff;
      end
   end

   csa_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SERVERS)) u_finish_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (idx_ff),
      .wr_data (fin_wr),
      .rd_addr (rd_addr),
      .rd_data (fin_q)
   );

   csa_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SERVERS)) u_count_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (idx_ff),
      .wr_data (cnt_wr),
      .rd_addr (rd_addr),
      .rd_data (cnt_q)
   );

   // Entries never written read as zero.
   assign fin_rd = rd_valid_ff ? fin_q : '0;
   assign cnt_rd = rd_valid_ff ? cnt_q : '0;

   assign sum_wide = {1'b0, arrival_ff} + {1'b0, service_ff};
   assign fin_wr   = sum_wide[DATA_W] ? '1 : sum_wide[DATA_W-1:0];
   assign cnt_wr   = (cnt_rd == '1) ? cnt_rd : cnt_rd + DATA_W'(1);

   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign status.free       = (fin_rd <= arrival_ff);
   assign status.search_end = ((cnt_ff + CNT_W'(1)) == n_ff);
   assign status.last_entry = last_entry;
   assign status.match      = (cnt_rd == best_ff);
   assign status.last_match = (idx_ff == last_idx_ff);
   assign status.slot_free  = slot_free;

   always_comb begin
      n_in          = csr_write ? n_clamped : n_ff;
      idx_in        = rd_addr;
      sp_in         = sp_ff;
      cnt_in        = cnt_ff;
      arrival_in    = arrival_ff;
      service_in    = service_ff;
      best_in       = best_ff;
      last_idx_in   = last_idx_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_server_in = rsp_server_ff;
      rsp_served_in = rsp_served_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.accept) begin
         arrival_in  = req_arrival_time;
         service_in  = req_service_time;
         cnt_in      = '0;
         best_in     = '0;
         last_idx_in = '0;
         if (req_action == ACTION_ASSIGN) begin
            sp_in = start_idx;
         end
      end
      if (cmd.step) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.track_max && (cnt_rd >= best_ff)) begin
         best_in     = cnt_rd;
         last_idx_in = idx_ff;
      end
      if (cmd.commit) begin
         valid_in[idx_ff] = 1'b1;
         sp_in            = sp_next;
         rsp_valid_in     = 1'b1;
         rsp_kind_in      = KIND_ASSIGNED;
         rsp_server_in    = SERVER_W'(idx_ff);
         rsp_served_in    = cnt_wr;
         rsp_last_in      = 1'b1;
      end
      if (cmd.drop) begin
         sp_in         = sp_next;
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_DROPPED;
         rsp_server_in = '0;
         rsp_served_in = '0;
         rsp_last_in   = 1'b1;
      end
      if (cmd.list_emit) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_BUSIEST;
         rsp_server_in = SERVER_W'(idx_ff);
         rsp_served_in = cnt_rd;
         rsp_last_in   = status.last_match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= CNT_W'(N_RESET);
         sp_ff        <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         n_ff         <= n_in;
         sp_ff        <= sp_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         rd_valid_ff  <= valid_ff[rd_addr];
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      arrival_ff    <= arrival_in;
      service_ff    <= service_in;
      best_ff       <= best_in;
      last_idx_ff   <= last_idx_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_server_ff <= rsp_server_in;
      rsp_served_ff <= rsp_served_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_server = rsp_server_ff;
   assign rsp_served = rsp_served_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

### sv/csa_checker.sv
// Port-level checks for the circular server assigner, bound to its top level.
// Depends on csa_pkg and circular_server_assigner.
module csa_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [csa_pkg::KIND_W-1:0]   rsp_kind,
   input logic [csa_pkg::SERVER_W-1:0] rsp_server,
   input logic [csa_pkg::DATA_W-1:0]   rsp_served,
   input logic                         rsp_last
);

   import csa_pkg::*;

   // A result that is not taken stays offered unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_server)
         && $stable(rsp_served) && $stable(rsp_last))
      else $error("result changed while stalled");

   // One request is worked on at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   // A dropped request reports no server and no count, and ends its request.
   a_drop_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DROPPED) |-> rsp_last && (rsp_server == '0)
         && (rsp_served == '0))
      else $error("malformed dropped result");

   // An assignment is the only result of its request and its count is nonzero.
   a_assign_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ASSIGNED) |-> rsp_last && (rsp_served != '0))
      else $error("malformed assignment result");

   // Only the three defined result kinds appear.
   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_ASSIGNED) || (rsp_kind == KIND_DROPPED)
         || (rsp_kind == KIND_BUSIEST))
      else $error("undefined result kind");

endmodule

bind circular_server_assigner csa_checker u_csa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_kind   (rsp_kind),
   .rsp_server (rsp_server),
   .rsp_served (rsp_served),
   .rsp_last   (rsp_last)
);
